/* src/ksm_pkg.sv */
// Shared types and helper functions for the keyframe sort and min/max block.
package ksm_pkg;

    // One stored keyframe: unsigned Q16.16 time and three signed Q16.16 values.
    typedef struct packed {
        logic        [31:0] time_q;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } t_key;

    // Signed minimum of two Q16.16 values.
    function automatic logic signed [31:0] smin(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        return (a < b) ? a : b;
    endfunction

    // Signed maximum of two Q16.16 values.
    function automatic logic signed [31:0] smax(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        return (a > b) ? a : b;
    endfunction

endpackage

/* src/keyframe_sort_minmax_core.sv */
// Keyframe collector that insertion-sorts keys by time in a memory and emits them in order.

// The block takes one keyframe word at a time (time, x, y, z, last flag) and keeps the
// set sorted by ascending time in a single-port-write, single-port-read memory with
// registered read data. A load walks down from the newest stored key, reading one
// entry per cycle and moving every key with a later time one place up, so equal times
// keep their load order. The first key of a set is written straight to the front; any
// later key walks past every stored key with a later time, whether it stops in the
// middle of the set or lands at the front. This walk through the memory port is what
// sets the load rate.
// The running minimum and maximum over all x, y and z values are folded in when a key
// is taken. A key that arrives with the memory full is dropped and flags dropped_keys.
// The word marked last closes the set: every stored key is then read back in order and
// offered on the output one word at a time (read, loaded, then held until taken),
// each tagged with its sorted position, the set's min and max, the drop flag, and
// final_key on the last one. The block takes no new input until the whole set has been
// delivered, after which it starts an empty set. No clearing pass is needed at reset.
module keyframe_sort_minmax_core #(
    parameter int MAX_KEYS = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Input channel
    input  logic               i_valid,
    output logic               o_ready,
    input  logic        [31:0] i_key_time,
    input  logic signed [31:0] i_key_x,
    input  logic signed [31:0] i_key_y,
    input  logic signed [31:0] i_key_z,
    input  logic               i_last_key,
    // Output channel
    output logic               o_valid,
    input  logic               i_ready,
    output logic        [31:0] o_out_time,
    output logic signed [31:0] o_out_x,
    output logic signed [31:0] o_out_y,
    output logic signed [31:0] o_out_z,
    output logic         [5:0] o_out_index,
    output logic signed [31:0] o_lowest_value,
    output logic signed [31:0] o_highest_value,
    output logic               o_dropped_keys,
    output logic               o_final_key
);

    import ksm_pkg::*;

    localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int CW = $clog2(MAX_KEYS + 1);
    localparam logic [CW-1:0] FULL = CW'(MAX_KEYS);

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_SEARCH   = 6'b000010,
        S_PLACE    = 6'b000100,
        S_EMIT_RD  = 6'b001000,
        S_EMIT_LD  = 6'b010000,
        S_EMIT_OUT = 6'b100000
    } t_state;

    // Key memory: written at one address and read at one address per cycle.
    t_key mem [MAX_KEYS];

    t_state                r_state, n_state;
    logic [CW-1:0]         r_count, n_count;
    logic signed [31:0]    r_min, n_min;
    logic signed [31:0]    r_max, n_max;
    logic                  r_ovf, n_ovf;
    logic                  r_last, n_last;
    t_key                  r_key, n_key;
    logic [AW-1:0]         r_pos, n_pos;
    logic [AW-1:0]         r_emit_idx, n_emit_idx;
    t_key                  r_rdata;

    // Output holding registers.
    t_key                  r_out, n_out;
    logic [5:0]            r_out_index, n_out_index;
    logic                  r_out_final, n_out_final;

    // Memory port controls.
    logic                  we;
    logic [AW-1:0]         waddr;
    t_key                  wdata;
    logic                  re;
    logic [AW-1:0]         raddr;

    logic                  in_acc;
    logic                  out_acc;
    logic signed [31:0]    base_min, base_max;
    logic [AW-1:0]         last_addr;

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_EMIT_OUT);
    assign in_acc  = i_valid && o_ready;
    assign out_acc = o_valid && i_ready;

    // Address of the newest stored key; only used while the count is nonzero.
    assign last_addr = AW'(r_count - CW'(1));

    // The first key of a set seeds min and max from its own x value.
    assign base_min = (r_count == '0) ? i_key_x : r_min;
    assign base_max = (r_count == '0) ? i_key_x : r_max;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_min       = r_min;
        n_max       = r_max;
        n_ovf       = r_ovf;
        n_last      = r_last;
        n_key       = r_key;
        n_pos       = r_pos;
        n_emit_idx  = r_emit_idx;
        n_out       = r_out;
        n_out_index = r_out_index;
        n_out_final = r_out_final;
        we          = 1'b0;
        waddr       = r_pos;
        wdata       = r_key;
        re          = 1'b0;
        raddr       = r_pos;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_key  = '{time_q: i_key_time, x: i_key_x, y: i_key_y, z: i_key_z};
                    n_last = i_last_key;
                    if (r_count == FULL) begin
                        // Memory full: the key is dropped, but a last flag still closes.
                        n_ovf = 1'b1;
                        if (i_last_key) begin
                            n_emit_idx = '0;
                            n_state    = S_EMIT_RD;
                        end
                    end else begin
                        n_min = smin(smin(smin(base_min, i_key_x), i_key_y), i_key_z);
                        n_max = smax(smax(smax(base_max, i_key_x), i_key_y), i_key_z);
                        if (r_count == '0) begin
                            // Empty set: the key goes straight to the front.
                            we      = 1'b1;
                            waddr   = '0;
                            wdata   = n_key;
                            n_count = CW'(1);
                            if (i_last_key) begin
                                n_emit_idx = '0;
                                n_state    = S_EMIT_RD;
                            end
                        end else begin
                            re      = 1'b1;
                            raddr   = last_addr;
                            n_pos   = last_addr;
                            n_state = S_SEARCH;
                        end
                    end
                end
            end

            S_SEARCH: begin
                // r_rdata holds the entry at r_pos.
                if (r_rdata.time_q > r_key.time_q) begin
                    we    = 1'b1;
                    waddr = r_pos + AW'(1);
                    wdata = r_rdata;
                    if (r_pos == '0) begin
                        n_state = S_PLACE;
                    end else begin
                        re    = 1'b1;
                        raddr = r_pos - AW'(1);
                        n_pos = r_pos - AW'(1);
                    end
                end else begin
                    we      = 1'b1;
                    waddr   = r_pos + AW'(1);
                    wdata   = r_key;
                    n_count = r_count + CW'(1);
                    n_emit_idx = '0;
                    n_state = r_last ? S_EMIT_RD : S_IDLE;
                end
            end

            S_PLACE: begin
                we      = 1'b1;
                waddr   = '0;
                wdata   = r_key;
                n_count = r_count + CW'(1);
                n_emit_idx = '0;
                n_state = r_last ? S_EMIT_RD : S_IDLE;
            end

            S_EMIT_RD: begin
                re      = 1'b1;
                raddr   = r_emit_idx;
                n_state = S_EMIT_LD;
            end

            S_EMIT_LD: begin
                n_out       = r_rdata;
                n_out_index = 6'(r_emit_idx);
                n_out_final = (r_emit_idx == last_addr);
                n_state     = S_EMIT_OUT;
            end

            S_EMIT_OUT: begin
                if (out_acc) begin
                    if (r_out_final) begin
                        // Set delivered: start an empty one.
                        n_count = '0;
                        n_min   = '0;
                        n_max   = '0;
                        n_ovf   = 1'b0;
                        n_state = S_IDLE;
                    end else begin
                        n_emit_idx = r_emit_idx + AW'(1);
                        n_state    = S_EMIT_RD;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_min   <= '0;
            r_max   <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_min   <= n_min;
            r_max   <= n_max;
            r_ovf   <= n_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        r_last      <= n_last;
        r_key       <= n_key;
        r_pos       <= n_pos;
        r_emit_idx  <= n_emit_idx;
        r_out       <= n_out;
        r_out_index <= n_out_index;
        r_out_final <= n_out_final;
    end

    // Memory write port.
    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Memory read port, registered data.
    always_ff @(posedge i_clk) begin
        if (re) begin
            r_rdata <= mem[raddr];
        end
    end

    assign o_out_time      = r_out.time_q;
    assign o_out_x         = r_out.x;
    assign o_out_y         = r_out.y;
    assign o_out_z         = r_out.z;
    assign o_out_index     = r_out_index;
    assign o_lowest_value  = r_min;
    assign o_highest_value = r_max;
    assign o_dropped_keys  = r_ovf;
    assign o_final_key     = r_out_final;

    // The stored count never exceeds the memory depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL)
        else $error("key count above capacity");

    // The insertion walk only visits stored entries.
    a_search_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEARCH) |-> (CW'(r_pos) < r_count))
        else $error("search position outside stored keys");

    // An offered word always comes from a stored entry.
    a_emit_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (CW'(r_emit_idx) < r_count))
        else $error("emit index outside stored keys");

    // Delivering the final word of a run empties the set.
    a_run_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && r_out_final) |=> (r_count == '0 && !r_ovf && r_state == S_IDLE))
        else $error("set not cleared after final word");

endmodule
